[rtl/string_to_integer_parser_core_macros.svh]
// assertion macros used by the parser core rtl
`ifndef STRING_TO_INTEGER_PARSER_CORE_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge out of reset
`define STOI_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("stoi assertion failed");

// antecedent implies consequent in the same cycle
`define STOI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stoi implication failed");

// antecedent implies consequent in the next cycle
`define STOI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stoi next-cycle implication failed");

`else

`define STOI_ASSERT(label, cond)
`define STOI_ASSERT_IMP(label, ante, cons)
`define STOI_ASSERT_NXT(label, ante, cons)

`endif

`endif

[rtl/stoi_pkg.sv]
// shared constants, types and character helpers for the string parser
package stoi_pkg;

  // parse phases
  localparam logic [2:0] PH_SPACE  = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_HEXX   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_SKIP   = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_BASE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_WIDTH = 4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NUMBER_BASE   = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNSIGNED_MODE = 4'd1;

  // base handling
  localparam int unsigned BASE_WIDTH = 6;
  localparam int unsigned CFG_DATA_WIDTH = 6;
  localparam logic [BASE_WIDTH-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_WIDTH-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_WIDTH-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_WIDTH-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_WIDTH-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_WIDTH-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_WIDTH-1:0] DIGIT_NONE = 6'd63;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // controls for one accumulate step
  typedef struct packed {
    logic negative;
    logic unsigned_mode;
    logic range;
  } acc_ctrl_t;

  // digit value of a character, DIGIT_NONE when it is no digit at all
  function automatic logic [BASE_WIDTH-1:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      t = c - CH_UA + 8'd10;
    end else begin
      t = {2'b00, DIGIT_NONE};
    end
    return t[BASE_WIDTH-1:0];
  endfunction

  // whitespace: tab through carriage return, and space
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

[rtl/stoi_accum.sv]
// one multiply-add step of the accumulator with range check
module stoi_accum #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic [VALUE_WIDTH-1:0]             acc,
  input  logic [stoi_pkg::BASE_WIDTH-1:0]    base,
  input  logic [stoi_pkg::BASE_WIDTH-1:0]    digit,
  input  stoi_pkg::acc_ctrl_t                ctrl,
  output logic [VALUE_WIDTH-1:0]             acc_nxt,
  output logic                               range_nxt
);

  localparam int unsigned PW = VALUE_WIDTH + stoi_pkg::BASE_WIDTH;

  logic [stoi_pkg::BASE_WIDTH-1:0] base_c;
  logic [VALUE_WIDTH-1:0]          limit;
  logic [PW-1:0]                   sum;
  logic                            over;

  // base below two behaves as two
  assign base_c = (base < stoi_pkg::BASE_MIN) ? stoi_pkg::BASE_MIN : base;

  // largest magnitude allowed for the sign and mode
  always_comb begin
    if (ctrl.unsigned_mode) begin
      limit = '1;
    end else if (ctrl.negative) begin
      limit = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      limit = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  end

  // acc * base + digit compared against the limit, no division needed
  assign sum  = PW'(acc) * PW'(base_c) + PW'(digit);
  assign over = sum > PW'(limit);

  // apply the step
  always_comb begin
    acc_nxt   = acc;
    range_nxt = ctrl.range;
    if (ctrl.unsigned_mode && ctrl.negative) begin
      if (digit != '0) begin
        range_nxt = 1'b1;
      end
    end else if (!ctrl.range) begin
      if (over) begin
        range_nxt = 1'b1;
      end else begin
        acc_nxt = sum[VALUE_WIDTH-1:0];
      end
    end
  end

endmodule

[rtl/string_to_integer_parser_core.sv]
// streaming strtol-style parser, one character per request
//
// Input channel (in_valid/in_ready/in_character) takes one byte per request;
// a zero byte ends the string. Leading whitespace, an optional sign and a
// 0x prefix (base 16 or automatic base) are taken, then digits of the base.
// At the first non-digit or the terminator one result request goes out on
// the output channel (out_value, out_consumed_count, out_status); bytes after
// it are dropped until the terminator.
// Config port: cfg_we writes cfg_wdata to register cfg_index (0 number_base,
// 1 unsigned_mode); write only while the block is idle.
// Path: a byte waits in the input register, then the parse step writes the
// result register. Throughput: one byte per cycle unless stalled (below);
// the step is one 64x6 multiply-add and a compare against the range limit,
// between the input and result registers.
// Reset (synchronous, rst_n low) clears the parse state, empties both
// registers and sets number_base to 10 and unsigned_mode to 0.
// Stall: while a result waits, bytes that make no result keep flowing; a
// byte that would make one waits in the input register, and in_ready drops.
`include "string_to_integer_parser_core_macros.svh"

module string_to_integer_parser_core #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [stoi_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [stoi_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata,
  // input characters
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_character,
  // results
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [VALUE_WIDTH-1:0]                out_value,
  output logic [COUNT_WIDTH-1:0]                out_consumed_count,
  output logic [1:0]                            out_status
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [VALUE_WIDTH-1:0] VAL_ALL = '1;
  localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  // config registers
  logic [stoi_pkg::BASE_WIDTH-1:0] nb_r;
  logic                            um_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;

  // parse state
  logic [2:0]                      ph_r, ph_nxt;
  logic [VALUE_WIDTH-1:0]          acc_r, acc_nxt;
  logic                            neg_r, neg_nxt;
  logic                            seen_r, seen_nxt;
  logic [COUNT_WIDTH-1:0]          pos_r, pos_nxt, pos_inc;
  logic [stoi_pkg::BASE_WIDTH-1:0] ab_r, ab_nxt;
  logic                            rng_r, rng_nxt;

  // result register
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_value_r;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic [1:0]             out_status_r;

  // step outputs
  logic                   emit;
  logic [VALUE_WIDTH-1:0] ev;
  logic [COUNT_WIDTH-1:0] ec;
  logic [1:0]             es;
  logic                   fire;

  // step helpers
  logic [stoi_pkg::BASE_WIDTH-1:0] acc_base;
  logic [stoi_pkg::BASE_WIDTH-1:0] digit;
  logic                            dig_ok;
  logic                            bad_base;
  logic [VALUE_WIDTH-1:0]          acc_new;
  logic                            rng_new;
  stoi_pkg::acc_ctrl_t             acc_ctrl;
  logic                            cont, clr, fin;
  logic [2:0]                      cur;
  logic [stoi_pkg::BASE_WIDTH-1:0] ab_v;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r <= stoi_pkg::BASE_DEC;
      um_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stoi_pkg::CFG_NUMBER_BASE:   nb_r <= cfg_wdata[stoi_pkg::BASE_WIDTH-1:0];
        stoi_pkg::CFG_UNSIGNED_MODE: um_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake: a byte steps when its result, if any, has room
  assign fire     = s1_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_character;
    end
  end

  // base the digit would be taken in, for the phase this byte lands in
  always_comb begin
    unique case (ph_r)
      stoi_pkg::PH_SPACE:
        acc_base = (nb_r == stoi_pkg::BASE_AUTO) ? stoi_pkg::BASE_DEC : nb_r;
      stoi_pkg::PH_SIGN:
        acc_base = (ab_r == stoi_pkg::BASE_AUTO) ? stoi_pkg::BASE_DEC : ab_r;
      stoi_pkg::PH_ZERO:
        acc_base = (ab_r == stoi_pkg::BASE_AUTO) ? stoi_pkg::BASE_OCT : ab_r;
      stoi_pkg::PH_HEXX:
        acc_base = stoi_pkg::BASE_HEX;
      default:
        acc_base = ab_r;
    endcase
  end

  assign digit    = stoi_pkg::digit_of(s1_char_r);
  assign dig_ok   = digit < acc_base;
  assign bad_base = (nb_r == stoi_pkg::BASE_ONE) || (nb_r > stoi_pkg::BASE_MAX);
  assign pos_inc  = (pos_r == CNT_MAX) ? pos_r : pos_r + COUNT_WIDTH'(1);

  assign acc_ctrl.negative      = neg_r;
  assign acc_ctrl.unsigned_mode = um_r;
  assign acc_ctrl.range         = rng_r;

  stoi_accum #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_accum (
    .acc       (acc_r),
    .base      (acc_base),
    .digit     (digit),
    .ctrl      (acc_ctrl),
    .acc_nxt   (acc_new),
    .range_nxt (rng_new)
  );

  // parse step for the byte in the input register
  always_comb begin
    ph_nxt   = ph_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    seen_nxt = seen_r;
    pos_nxt  = pos_r;
    rng_nxt  = rng_r;
    ab_v     = ab_r;
    emit     = 1'b0;
    ev       = '0;
    ec       = '0;
    es       = stoi_pkg::ST_OK;
    clr      = 1'b0;
    fin      = 1'b0;
    cont     = 1'b1;
    cur      = ph_r;

    // after the number: drop bytes until the terminator
    if (ph_r > stoi_pkg::PH_DIGITS) begin
      cont = 1'b0;
      if (s1_char_r == stoi_pkg::CH_NUL) begin
        clr = 1'b1;
      end
    end

    // leading whitespace
    if (cont && cur == stoi_pkg::PH_SPACE) begin
      if (s1_char_r == stoi_pkg::CH_NUL) begin
        emit = 1'b1;
        es   = bad_base ? stoi_pkg::ST_BAD_BASE : stoi_pkg::ST_OK;
        clr  = 1'b1;
        cont = 1'b0;
      end else if (stoi_pkg::is_space(s1_char_r)) begin
        pos_nxt = pos_inc;
        cont    = 1'b0;
      end else begin
        ab_v = nb_r;
        if (bad_base) begin
          emit = 1'b1;
          es   = stoi_pkg::ST_BAD_BASE;
          fin  = 1'b1;
          cont = 1'b0;
        end else begin
          cur    = stoi_pkg::PH_SIGN;
          ph_nxt = stoi_pkg::PH_SIGN;
          if (s1_char_r == stoi_pkg::CH_PLUS || s1_char_r == stoi_pkg::CH_MINUS) begin
            neg_nxt = (s1_char_r == stoi_pkg::CH_MINUS);
            pos_nxt = pos_inc;
            cont    = 1'b0;
          end
        end
      end
    end

    // first character after the sign
    if (cont && cur == stoi_pkg::PH_SIGN) begin
      cont = 1'b0;
      if (s1_char_r == stoi_pkg::CH_ZERO &&
          (ab_v == stoi_pkg::BASE_AUTO || ab_v == stoi_pkg::BASE_HEX)) begin
        seen_nxt = 1'b1;
        ph_nxt   = stoi_pkg::PH_ZERO;
        pos_nxt  = pos_inc;
      end else begin
        if (ab_v == stoi_pkg::BASE_AUTO) begin
          ab_v = stoi_pkg::BASE_DEC;
        end
        if (dig_ok) begin
          seen_nxt = 1'b1;
          acc_nxt  = acc_new;
          rng_nxt  = rng_new;
          ph_nxt   = stoi_pkg::PH_DIGITS;
          pos_nxt  = pos_inc;
        end else begin
          emit = 1'b1;
          fin  = 1'b1;
        end
      end
    end

    // leading zero: maybe an x follows
    if (cont && cur == stoi_pkg::PH_ZERO) begin
      if ((s1_char_r | stoi_pkg::CASE_BIT) == stoi_pkg::CH_LX) begin
        ph_nxt  = stoi_pkg::PH_HEXX;
        pos_nxt = pos_inc;
        cont    = 1'b0;
      end else begin
        if (ab_v == stoi_pkg::BASE_AUTO) begin
          ab_v = stoi_pkg::BASE_OCT;
        end
        cur    = stoi_pkg::PH_DIGITS;
        ph_nxt = stoi_pkg::PH_DIGITS;
      end
    end

    // after the prefix a hex digit must follow
    if (cont && cur == stoi_pkg::PH_HEXX) begin
      cont = 1'b0;
      if (dig_ok) begin
        ab_v    = stoi_pkg::BASE_HEX;
        acc_nxt = acc_new;
        rng_nxt = rng_new;
        ph_nxt  = stoi_pkg::PH_DIGITS;
        pos_nxt = pos_inc;
      end else begin
        // count stops at the zero, the x is not part of the number
        emit = 1'b1;
        ec   = (pos_r == CNT_MAX) ? CNT_MAX : pos_r - COUNT_WIDTH'(1);
        fin  = 1'b1;
      end
    end

    // digit run
    if (cont) begin
      if (dig_ok) begin
        acc_nxt = acc_new;
        rng_nxt = rng_new;
        pos_nxt = pos_inc;
      end else begin
        emit = 1'b1;
        ec   = seen_r ? pos_r : '0;
        if (rng_r) begin
          es = stoi_pkg::ST_RANGE;
          if (um_r) begin
            ev = neg_r ? '0 : VAL_ALL;
          end else begin
            ev = neg_r ? VAL_MIN : VAL_MAX;
          end
        end else begin
          ev = neg_r ? ('0 - acc_r) : acc_r;
        end
        fin = 1'b1;
      end
    end

    ab_nxt = ab_v;

    // end of number: skip the tail, or restart on the terminator
    if (fin) begin
      if (s1_char_r == stoi_pkg::CH_NUL) begin
        clr = 1'b1;
      end else begin
        ph_nxt = stoi_pkg::PH_SKIP;
      end
    end

    // new string
    if (clr) begin
      ph_nxt   = stoi_pkg::PH_SPACE;
      acc_nxt  = '0;
      neg_nxt  = 1'b0;
      seen_nxt = 1'b0;
      pos_nxt  = '0;
      ab_nxt   = stoi_pkg::BASE_AUTO;
      rng_nxt  = 1'b0;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= stoi_pkg::PH_SPACE;
      acc_r  <= '0;
      neg_r  <= 1'b0;
      seen_r <= 1'b0;
      pos_r  <= '0;
      ab_r   <= stoi_pkg::BASE_AUTO;
      rng_r  <= 1'b0;
    end else if (fire) begin
      ph_r   <= ph_nxt;
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
      seen_r <= seen_nxt;
      pos_r  <= pos_nxt;
      ab_r   <= ab_nxt;
      rng_r  <= rng_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_value_r  <= ev;
      out_count_r  <= ec;
      out_status_r <= es;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_consumed_count = out_count_r;
  assign out_status         = out_status_r;

  // checks
  `STOI_ASSERT_IMP(a_result_slot_free, fire && emit, !out_valid_r || out_ready)
  `STOI_ASSERT_IMP(a_bad_base_zero, out_valid_r && out_status_r == stoi_pkg::ST_BAD_BASE,
                   out_value_r == '0 && out_count_r == '0)
  `STOI_ASSERT(a_acc_zero_without_digits, seen_r || acc_r == '0)
  `STOI_ASSERT_IMP(a_range_needs_digits, rng_r, seen_r)

endmodule
